// ===== rtl/core/bfmk_pkg.sv =====
// shared types and constants for the bloom filter core
package bfmk_pkg;

    localparam int unsigned FILTER_BITS_DEF = 4096;
    localparam int unsigned MAX_HASHES_DEF  = 8;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned M_W             = 13;
    localparam int unsigned K_W             = 4;

    localparam logic CFG_FILTER_BITS = 1'b0;
    localparam logic CFG_HASH_COUNT  = 1'b1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic        last;
    } byte_req_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== rtl/core/bfmk_ram.sv =====
// generic single-port ram with registered read
module bfmk_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/bfmk_front.sv =====
// input stage and request queue between front and back
module bfmk_front import bfmk_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  byte_req_t in_req,
    output logic      q_valid,
    input  logic      q_ready,
    output byte_req_t q_req
);

    byte_req_t buf_reg [2];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_req;
        end
    end

endmodule

// ===== rtl/core/bfmk_back.sv =====
// hash lanes, finalize sequencer, modulo unit and filter access
module bfmk_back import bfmk_pkg::*; #(
    parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
    parameter int unsigned MAX_HASHES  = MAX_HASHES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  byte_req_t      q_req,
    input  logic [M_W-1:0] m_cfg,
    input  logic [K_W-1:0] k_cfg,
    output logic           res_valid,
    input  logic           res_ready,
    output logic           res_query,
    output logic           res_found
);

    localparam int unsigned AW = $clog2(FILTER_BITS);
    localparam int unsigned LW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int unsigned KCW = $clog2(MAX_HASHES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BLK1, S_BLK2, S_BLK3, S_FIN0, S_FIN1, S_FIN2, S_FIN3, S_FIN4,
        S_MOD, S_MEM, S_CHK, S_OUT, S_CLR
    } state_t;

    state_t      state_reg;
    logic [31:0] lane_reg [MAX_HASHES];
    logic [31:0] part_reg;
    logic [1:0]  nib_reg;
    logic [31:0] len_reg;
    logic [31:0] k1_reg;
    logic [31:0] h_reg;
    logic [LW-1:0] lane_idx_reg;
    logic [KCW-1:0] k_reg;
    logic [AW:0] m_reg;
    logic [32+AW:0] rem_reg;
    logic [5:0]  bit_reg;
    logic        cmd_reg, found_reg, part_has_reg;
    logic        out_valid_reg, out_query_reg, out_found_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] clr_reg;
    logic        we;
    logic        rd;
    logic [AW-1:0] ram_addr;
    logic        ram_wdata;
    logic [AW:0] m_lim;
    logic [KCW-1:0] k_lim;
    logic [31:0] part_new;
    logic [AW:0] rem_try;
    logic        out_go;

    always_comb
    begin
        if (m_cfg == '0)
            m_lim = (AW+1)'(1);
        else if ({19'd0, m_cfg} > 32'(FILTER_BITS))
            m_lim = (AW+1)'(FILTER_BITS);
        else
            m_lim = (AW+1)'(m_cfg);
        if (k_cfg == '0)
            k_lim = KCW'(1);
        else if (32'(k_cfg) > 32'(MAX_HASHES))
            k_lim = KCW'(MAX_HASHES);
        else
            k_lim = KCW'(k_cfg);
        part_new = part_reg | (32'(q_req.data) << {nib_reg, 3'b000});
        rem_try  = {rem_reg[32+AW-1:32], h_reg[31]} - m_reg;
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_query = out_query_reg;
    assign res_found = out_found_reg;
    assign out_go    = !out_valid_reg || res_ready;
    assign we = ((state_reg == S_MEM) && (cmd_reg == CMD_INSERT)) || (state_reg == S_CLR);
    assign ram_addr  = (state_reg == S_CLR) ? clr_reg : addr_reg;
    assign ram_wdata = (state_reg != S_CLR);

    bfmk_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_store (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_HASHES; i++)
                lane_reg[i] <= 32'(i);
            part_reg <= '0;
            nib_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            if ((state_reg == S_OUT) && out_go)
                out_valid_reg <= 1'b1;
            else if (res_valid && res_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(FILTER_BITS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        len_reg <= len_reg + 32'd1;
                        cmd_reg <= q_req.cmd;
                        m_reg   <= m_lim;
                        k_reg   <= k_lim;
                        nib_reg <= nib_reg + 2'd1;
                        if (nib_reg == 2'd3)
                        begin
                            part_reg  <= '0;
                            part_has_reg <= 1'b0;
                            k1_reg    <= part_new * C1;
                            state_reg <= S_BLK1;
                        end
                        else
                        begin
                            part_reg  <= part_new;
                            part_has_reg <= 1'b1;
                            k1_reg    <= part_new * C1;
                            state_reg <= q_req.last ? S_BLK3 : S_IDLE;
                        end
                        found_reg    <= 1'b1;
                        lane_idx_reg <= '0;
                        bit_reg      <= q_req.last ? 6'd1 : 6'd0;
                    end
                end
                S_BLK1:
                begin
                    k1_reg    <= rotl(k1_reg, 15) * C2;
                    state_reg <= S_BLK2;
                end
                S_BLK2:
                begin
                    for (int i = 0; i < MAX_HASHES; i++)
                        lane_reg[i] <= rotl(lane_reg[i] ^ k1_reg, 13) * 32'd5 + MIX_ADD;
                    state_reg <= (bit_reg[0]) ? S_FIN0 : S_IDLE;
                end
                S_BLK3:
                begin
                    k1_reg    <= rotl(k1_reg, 15) * C2;
                    state_reg <= S_FIN0;
                end
                S_FIN0:
                begin
                    h_reg <= (lane_reg[lane_idx_reg] ^ (part_has_reg ? k1_reg : 32'd0))
                             ^ len_reg;
                    state_reg <= S_FIN1;
                end
                S_FIN1:
                begin
                    h_reg     <= (h_reg ^ (h_reg >> 16)) * F1;
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    h_reg     <= (h_reg ^ (h_reg >> 13)) * F2;
                    state_reg <= S_FIN3;
                end
                S_FIN3:
                begin
                    h_reg     <= h_reg ^ (h_reg >> 16);
                    rem_reg   <= '0;
                    bit_reg   <= 6'd0;
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (rem_try[AW] == 1'b0 &&
                        {rem_reg[32+AW-1:32], h_reg[31]} >= m_reg)
                        rem_reg[32+AW:32] <= {1'b0, rem_try[AW-1:0]};
                    else
                        rem_reg[32+AW:32] <= {rem_reg[32+AW-1:32], h_reg[31]};
                    h_reg   <= h_reg << 1;
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd31)
                        state_reg <= S_FIN4;
                end
                S_FIN4:
                begin
                    addr_reg  <= rem_reg[32+AW-1:32];
                    state_reg <= S_MEM;
                end
                S_MEM:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (rd == 1'b0)
                        found_reg <= 1'b0;
                    if (32'(lane_idx_reg) + 32'd1 >= 32'(k_reg))
                        state_reg <= S_OUT;
                    else
                    begin
                        lane_idx_reg <= lane_idx_reg + LW'(1);
                        state_reg    <= S_FIN0;
                    end
                end
                S_OUT:
                begin
                    if (out_go)
                    begin
                        out_query_reg <= cmd_reg;
                        out_found_reg <= (cmd_reg == CMD_INSERT) ? 1'b1 : found_reg;
                        for (int i = 0; i < MAX_HASHES; i++)
                            lane_reg[i] <= 32'(i);
                        part_reg  <= '0;
                        nib_reg   <= '0;
                        len_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/bloom_filter_murmur_keys_core.sv =====
// top level of the murmur-hashed bloom filter
//  channel | dir | tdata bits                     | tuser / tlast
//  s_axis  | in  | [7:0] key_byte                 | tuser[0] command, tlast last_byte
//  m_axis  | out | [0] was_query, [1] found       | none
//  cfg     | in  | index 0 filter size, 1 hashes  | write only
// non-final bytes are taken in the idle state; on a block boundary the block is first mixed in S_BLK1 and S_BLK2
// final byte runs, per hash lane, the finalize steps, the bit-serial modulo unit and the filter read and check
// a two-entry queue takes bytes while the back end works
// a waiting result holds the back end only when the next result is ready
// reset starts a clearing pass over every address of the filter store
module bloom_filter_murmur_keys_core import bfmk_pkg::*; #(
    parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
    parameter int unsigned MAX_HASHES  = MAX_HASHES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // key_byte
    input  logic             s_axis_tuser,   // command
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // was_query, found
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [M_W-1:0] m_reg;
    logic [K_W-1:0] k_reg;
    byte_req_t in_req, q_req;
    logic q_valid, q_ready, rq, rf;

    assign in_req = '{cmd: s_axis_tuser, data: s_axis_tdata, last: s_axis_tlast};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= M_W'(4096);
            k_reg <= K_W'(4);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FILTER_BITS)
                m_reg <= cfg_data[M_W-1:0];
            else
                k_reg <= cfg_data[K_W-1:0];
        end
    end

    bfmk_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    bfmk_back #(.FILTER_BITS(FILTER_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_cfg(m_reg), .k_cfg(k_reg), .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready), .res_query(rq), .res_found(rf)
    );

    assign m_axis_tdata = {6'd0, rf, rq};

endmodule

// ===== rtl/core/bfmk_checker.sv =====
// port-level checks for the bloom filter core
module bfmk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_ins: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("insert not found");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
        else $error("padding set");

endmodule

bind bloom_filter_murmur_keys_core bfmk_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
